### src/ccsp_pkg.sv
`default_nettype none

package ccsp_pkg;

	// Longest generator the datapath supports; the remainder has one bit fewer.
	localparam int MAX_GEN_LEN = 9;
	localparam int REM_W       = MAX_GEN_LEN - 1;
	localparam int LEN_W       = $clog2(MAX_GEN_LEN + 1);

	// Fixed widths of the configuration fields.
	localparam int GEN_BITS_W  = 9;
	localparam int GEN_LEN_W   = 4;
	localparam int COUNT_W     = 32;

	localparam int NARROW_W    = 4;
	localparam int WIDE_W      = 8;

	// Codeword bits produced by one input byte: two narrow codewords or one wide one.
	localparam int BITS_W      = (2 * (NARROW_W + REM_W) > WIDE_W + REM_W) ?
		2 * (NARROW_W + REM_W) : WIDE_W + REM_W;
	localparam int NBITS_W     = $clog2(BITS_W + 1);
	localparam int PAD_W       = 3;

	// Packing window: pending bits, padding bits and the new codeword bits.
	localparam int ACC_W       = BITS_W + 14;
	localparam int TOT_W       = $clog2(ACC_W + 1);

	// Output bytes per input byte: header or flush byte plus the full bytes.
	localparam int MAX_OUT     = (BITS_W + 7) / 8 + 1;
	localparam int OCNT_W      = $clog2(MAX_OUT + 1);

	localparam int FIFO_DEPTH  = 4;

	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	typedef enum logic [1:0] {
		REG_GEN_BITS,
		REG_GEN_LEN,
		REG_WIDE,
		REG_BYTE_COUNT
	} reg_idx_t;

	typedef struct packed {
		logic [GEN_BITS_W-1:0] gen_bits;
		logic [GEN_LEN_W-1:0]  gen_len;
		logic                  wide;
		logic [COUNT_W-1:0]    byte_count;
	} cfg_t;

	// One classified input byte on its way from the front end to the packer.
	typedef struct packed {
		logic               hdr;
		logic [PAD_W-1:0]   pad;
		logic [BITS_W-1:0]  bits;
		logic [NBITS_W-1:0] nbits;
		logic               last;
	} entry_t;

	// A zero length counts as one; lengths past the datapath are clipped.
	function automatic logic [LEN_W-1:0] eff_len(input logic [GEN_LEN_W-1:0] len);
		int l;
		l = int'(len);
		if (l < 1) l = 1;
		if (l > MAX_GEN_LEN) l = MAX_GEN_LEN;
		return LEN_W'(l);
	endfunction

endpackage

`default_nettype wire

### src/crc_codeword_stream_packer_top.sv
// A transfer into an idle block is queued, then loaded into the output holding register,
// which shows its first output byte. Bytes leave at one per cycle while pop is held and
// bytes wait; each input byte yields one to four, and the next loads as the last one leaves.
// A four-entry queue between the encoder and the packer lets either side stall alone.
// Reset (arst_n low, asynchronous) empties the queue and packer and restores register defaults.
`default_nettype none

module crc_codeword_stream_packer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ccsp_pkg::ADDR_W-1:0] paddr,
	input  logic [ccsp_pkg::DATA_W-1:0] pwdata,
	output logic [ccsp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  data_byte,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  out_byte,
	output logic                        last_byte
);
	import ccsp_pkg::*;

	cfg_t   cfg;
	entry_t wr_data;
	entry_t rd_data;
	logic   wr_en;
	logic   rd_en;
	logic   fifo_valid;

	ccsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ccsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.data_byte (data_byte),
		.fifo_full (full),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	ccsp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (full),
		.rd_en   (rd_en),
		.rd_data (rd_data),
		.valid   (fifo_valid)
	);

	ccsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent_valid (fifo_valid),
		.ent       (rd_data),
		.ent_pop   (rd_en),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

`default_nettype wire

### src/ccsp_regs.sv
`default_nettype none

module ccsp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ccsp_pkg::ADDR_W-1:0]  paddr,
	input  logic [ccsp_pkg::DATA_W-1:0]  pwdata,
	output logic [ccsp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output ccsp_pkg::cfg_t               cfg
);
	import ccsp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gen_bits   <= GEN_BITS_W'(11);
			cfg_q.gen_len    <= GEN_LEN_W'(4);
			cfg_q.wide       <= 1'b0;
			cfg_q.byte_count <= COUNT_W'(1);
		end else if (wr) begin
			unique case (idx)
				REG_GEN_BITS:   cfg_q.gen_bits   <= pwdata[GEN_BITS_W-1:0];
				REG_GEN_LEN:    cfg_q.gen_len    <= pwdata[GEN_LEN_W-1:0];
				REG_WIDE:       cfg_q.wide       <= pwdata[0];
				REG_BYTE_COUNT: cfg_q.byte_count <= pwdata[COUNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GEN_BITS:   prdata = DATA_W'(cfg_q.gen_bits);
			REG_GEN_LEN:    prdata = DATA_W'(cfg_q.gen_len);
			REG_WIDE:       prdata = DATA_W'(cfg_q.wide);
			REG_BYTE_COUNT: prdata = DATA_W'(cfg_q.byte_count);
		endcase
	end

endmodule

`default_nettype wire

### src/ccsp_front.sv
`default_nettype none

module ccsp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ccsp_pkg::cfg_t  cfg,
	input  logic            push,
	input  logic [7:0]      data_byte,
	input  logic            fifo_full,
	output logic            wr_en,
	output ccsp_pkg::entry_t wr_data
);
	import ccsp_pkg::*;

	// Bitwise long division; the remainder stays left aligned in REM_W bits so
	// that the generator length only changes where the result is read.
	function automatic logic [REM_W-1:0] crc_rem(
		input logic [WIDE_W-1:0] d,
		input logic              wide,
		input logic [REM_W-1:0]  gl
	);
		logic [REM_W-1:0] r;
		logic             fb;
		r = '0;
		for (int i = 0; i < WIDE_W; i++) begin
			if (wide || i < NARROW_W) begin
				fb = r[REM_W-1] ^ d[WIDE_W-1-i];
				r  = r << 1;
				if (fb) r = r ^ gl;
			end
		end
		return r;
	endfunction

	logic [COUNT_W-1:0]     seen_q;
	logic                   hdr_sent_q;

	logic [LEN_W-1:0]       glen;
	logic [LEN_W-1:0]       k;
	logic [LEN_W-1:0]       sh;
	logic [MAX_GEN_LEN-1:0] gen_ext;
	logic [REM_W-1:0]       gl;
	logic [REM_W-1:0]       rem_a;
	logic [REM_W-1:0]       rem_b;
	logic [REM_W-1:0]       rem_w;
	logic [NBITS_W-1:0]     clen_n;
	logic [NBITS_W-1:0]     clen_w;
	logic [BITS_W-1:0]      cw_hi;
	logic [BITS_W-1:0]      cw_lo;
	logic [BITS_W-1:0]      cw_wide;
	logic [2:0]             clen3;
	logic [5:0]             prod;
	logic [2:0]             rem3;
	logic [PAD_W-1:0]       pad;
	logic [COUNT_W-1:0]     seen_next;
	logic                   seen_max;

	assign glen    = eff_len(cfg.gen_len);
	assign k       = glen - LEN_W'(1);
	assign sh      = LEN_W'(REM_W) - k;
	assign gen_ext = MAX_GEN_LEN'(cfg.gen_bits);
	assign gl      = (gen_ext[REM_W-1:0] & ({REM_W{1'b1}} >> sh)) << sh;

	assign rem_a = crc_rem({data_byte[7:4], 4'b0000}, 1'b0, gl) >> sh;
	assign rem_b = crc_rem({data_byte[3:0], 4'b0000}, 1'b0, gl) >> sh;
	assign rem_w = crc_rem(data_byte, 1'b1, gl) >> sh;

	assign clen_n  = NBITS_W'(NARROW_W) + NBITS_W'(k);
	assign clen_w  = NBITS_W'(WIDE_W) + NBITS_W'(k);
	assign cw_hi   = (BITS_W'(data_byte[7:4]) << k) | BITS_W'(rem_a);
	assign cw_lo   = (BITS_W'(data_byte[3:0]) << k) | BITS_W'(rem_b);
	assign cw_wide = (BITS_W'(data_byte) << k) | BITS_W'(rem_w);

	// Padding brings codeword length * datawords * byte count to a whole byte;
	// only the low three bits of each factor matter.
	assign clen3 = cfg.wide ? clen_w[2:0] : clen_n[2:0];
	assign prod  = 6'(clen3) * 6'(cfg.byte_count[2:0]);
	assign rem3  = cfg.wide ? prod[2:0] : {prod[1:0], 1'b0};
	assign pad   = PAD_W'(3'd0 - rem3);

	assign seen_max  = (seen_q == {COUNT_W{1'b1}});
	assign seen_next = seen_max ? seen_q : seen_q + COUNT_W'(1);

	assign wr_en = push && !fifo_full;

	always_comb begin
		wr_data.hdr   = !hdr_sent_q;
		wr_data.pad   = hdr_sent_q ? '0 : pad;
		wr_data.bits  = cfg.wide ? cw_wide : ((cw_hi << clen_n) | cw_lo);
		wr_data.nbits = cfg.wide ? clen_w : NBITS_W'(clen_n << 1);
		wr_data.last  = !seen_max && (seen_next == cfg.byte_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			hdr_sent_q <= 1'b0;
		end else if (wr_en) begin
			seen_q     <= seen_next;
			hdr_sent_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### src/ccsp_fifo.sv
`default_nettype none

module ccsp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  ccsp_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output ccsp_pkg::entry_t rd_data,
	output logic             valid
);
	import ccsp_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	entry_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign valid   = (cnt_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) cnt_q <= cnt_q + CNT_W'(1);
			else if (rd_en && !wr_en) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### src/ccsp_back.sv
`default_nettype none

module ccsp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ent_valid,
	input  ccsp_pkg::entry_t ent,
	output logic             ent_pop,
	output logic             empty,
	input  logic             pop,
	output logic [7:0]       out_byte,
	output logic             last_byte
);
	import ccsp_pkg::*;

	logic [6:0]        pend_q;
	logic [2:0]        fill_q;
	logic [7:0]        hold_q [MAX_OUT];
	logic [OCNT_W-1:0] left_q;
	logic              last_q;

	logic [ACC_W-1:0]  acc;
	logic [TOT_W-1:0]  total;
	logic [TOT_W-1:0]  nb;
	logic [2:0]        rem;
	logic              flush;
	logic [7:0]        fl_byte;
	logic [7:0]        dl   [MAX_OUT];
	logic [7:0]        slot [MAX_OUT];
	logic [OCNT_W-1:0] n_out;
	logic              load;
	logic              xfer;

	// New bits join the pending bits of the previous byte below them.
	assign acc = (ACC_W'(pend_q) << (TOT_W'(ent.pad) + TOT_W'(ent.nbits)))
		| ACC_W'(ent.bits);
	assign total   = TOT_W'(fill_q) + TOT_W'(ent.pad) + TOT_W'(ent.nbits);
	assign nb      = total >> 3;
	assign rem     = total[2:0];
	assign flush   = ent.last && (rem != 3'd0);
	assign fl_byte = 8'(acc[7:0] << (4'd8 - {1'b0, rem}));

	always_comb begin
		for (int j = 0; j < MAX_OUT; j++) begin
			if (nb > TOT_W'(j)) begin
				dl[j] = 8'(acc >> (total - TOT_W'(8 * (j + 1))));
			end else begin
				dl[j] = fl_byte;
			end
		end
		slot[0] = ent.hdr ? 8'(ent.pad) : dl[0];
		for (int i = 1; i < MAX_OUT; i++) begin
			slot[i] = ent.hdr ? dl[i-1] : dl[i];
		end
		n_out = OCNT_W'(ent.hdr) + OCNT_W'(nb) + OCNT_W'(flush);
	end

	assign xfer      = pop && !empty;
	assign load      = ent_valid && ((left_q == '0) || ((left_q == OCNT_W'(1)) && pop));
	assign ent_pop   = load;
	assign empty     = (left_q == '0);
	assign out_byte  = hold_q[0];
	assign last_byte = last_q && (left_q == OCNT_W'(1));

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_OUT; i++) hold_q[i] <= slot[i];
		end else if (xfer) begin
			for (int i = 0; i < MAX_OUT - 1; i++) hold_q[i] <= hold_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			fill_q <= '0;
			left_q <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			left_q <= n_out;
			last_q <= ent.last;
			if (flush) begin
				pend_q <= '0;
				fill_q <= '0;
			end else begin
				pend_q <= acc[6:0] & (7'h7f >> (3'd7 - rem));
				fill_q <= rem;
			end
		end else if (xfer) begin
			left_q <= left_q - OCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### src/ccsp_checker.sv
`default_nettype none

module ccsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       last_byte,
	input logic       pready
);

	// A full queue means the packer has already taken work, so output is waiting.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue full while no output byte is waiting");

	// A byte taken into an idle block passes through the queue and the holding register to the output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty) |-> ##2 !empty)
		else $error("output byte missing two cycles after input transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_byte)))
		else $error("waiting output byte changed before its transfer");

	a_pready: assert property (@(posedge clk) pready)
		else $error("configuration port not ready");

endmodule

bind crc_codeword_stream_packer_top ccsp_checker u_ccsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.push      (push),
	.full      (full),
	.empty     (empty),
	.pop       (pop),
	.out_byte  (out_byte),
	.last_byte (last_byte),
	.pready    (pready)
);

`default_nettype wire
